// ===== src/bta_pkg.sv =====
// bta_pkg: request codes, field widths and the controller-to-datapath command
// bundle of the bakery ticket arbiter
// depends on nothing
package bta_pkg;

   localparam int REQ_TYPE_W = 2;
   localparam int TID_W      = 3;
   localparam int ASSIGNED_W = 32;

   localparam logic [REQ_TYPE_W-1:0] REQ_LOCK   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_UNLOCK = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 2'd2;

   typedef struct packed {
      logic start;
      logic scan_rd;
      logic finish;
   } cmd_type;

endpackage

// ===== src/bta_req_if.sv =====
// bta_req_if: request channel of the bakery ticket arbiter
// depends on bta_pkg
interface bta_req_if;
   logic                          valid;
   logic                          ready;
   logic [bta_pkg::REQ_TYPE_W-1:0] req_type;
   logic [bta_pkg::TID_W-1:0]      thread_id;

   modport source (output valid, output req_type, output thread_id, input ready);
   modport sink (input valid, input req_type, input thread_id, output ready);
endinterface

// ===== src/bta_rsp_if.sv =====
// bta_rsp_if: result channel of the bakery ticket arbiter
// depends on bta_pkg
interface bta_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           grant_valid;
   logic [bta_pkg::TID_W-1:0]      grant_thread;
   logic [bta_pkg::ASSIGNED_W-1:0] assigned_label;
   logic                           requester_granted;
   logic                           label_overflow;

   modport source (output valid, output grant_valid, output grant_thread,
                   output assigned_label, output requester_granted,
                   output label_overflow, input ready);
   modport sink (input valid, input grant_valid, input grant_thread,
                 input assigned_label, input requester_granted,
                 input label_overflow, output ready);
endinterface

// ===== src/bta_ram.sv =====
// bta_ram: generic single write port, single read port ram with registered read
// depends on nothing
module bta_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

// ===== src/bta_ctrl.sv =====
// bta_ctrl: sequencer of the bakery ticket arbiter (accept, label scan, update,
// result handshake)
// depends on bta_pkg
module bta_ctrl #(
   parameter int THREADS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bta_pkg::REQ_TYPE_W-1:0] req_type,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bta_pkg::cmd_type              cmd,
   output logic [$clog2(THREADS)-1:0]    scan_addr
);

   localparam int IDX_W = $clog2(THREADS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FINAL = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             finish;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign finish    = (state_ff == ST_FINAL) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in   = '0;
               state_in = (req_type == bta_pkg::REQ_CLEAR) ? ST_FINAL : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(THREADS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = finish || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign scan_addr   = cnt_ff;
   assign cmd.start   = accept;
   assign cmd.scan_rd = (state_ff == ST_SCAN);
   assign cmd.finish  = finish;

endmodule

// ===== src/bta_dpath.sv =====
// bta_dpath: flags, label store, max and winner scan, label update and result
// register of the bakery ticket arbiter
// depends on bta_pkg, bta_ram
module bta_dpath #(
   parameter int THREADS    = 8,
   parameter int LABEL_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bta_pkg::cmd_type               cmd,
   input  logic [$clog2(THREADS)-1:0]     scan_addr,
   input  logic [bta_pkg::REQ_TYPE_W-1:0] req_type,
   input  logic [bta_pkg::TID_W-1:0]      thread_id,
   output logic                           grant_valid,
   output logic [bta_pkg::TID_W-1:0]      grant_thread,
   output logic [bta_pkg::ASSIGNED_W-1:0] assigned_label,
   output logic                           requester_granted,
   output logic                           label_overflow
);

   localparam int IDX_W = $clog2(THREADS);
   localparam int EXT_W = IDX_W + bta_pkg::TID_W;

   logic [bta_pkg::REQ_TYPE_W-1:0] op_ff;
   logic [bta_pkg::TID_W-1:0]      tid_ff;
   logic [THREADS-1:0]             flag_ff, flag_in;
   logic [THREADS-1:0]             entry_vld_ff, entry_vld_in;
   logic [LABEL_BITS-1:0]          max_ff, best_ff, cur_ff;
   logic                           found_ff;
   logic [IDX_W-1:0]               win_ff;
   logic                           pend_vld_ff;
   logic [IDX_W-1:0]               pend_idx_ff;

   logic                           gv_ff, rg_ff, ovf_ff;
   logic [bta_pkg::TID_W-1:0]      gt_ff;
   logic [bta_pkg::ASSIGNED_W-1:0] al_ff;

   logic [LABEL_BITS-1:0] ram_rdata;
   logic [LABEL_BITS-1:0] rd_label;
   logic [LABEL_BITS-1:0] top_label;
   logic [LABEL_BITS-1:0] new_label;
   logic [EXT_W-1:0]      tid_ext, idx_ext, win_ext;
   logic [IDX_W-1:0]      tid_idx;
   logic                  in_range, is_upd, excl, do_lock, saturated, tid_wins;
   logic                  take;

   logic                           gv_in, rg_in;
   logic [bta_pkg::TID_W-1:0]      gt_in;
   logic [bta_pkg::ASSIGNED_W-1:0] al_in;
   logic [LABEL_BITS-1:0]          al_src;
   logic [IDX_W-1:0]               gt_src;

   bta_ram #(
      .WIDTH (LABEL_BITS),
      .DEPTH (THREADS)
   ) u_label_ram (
      .clock    (clock),
      .we       (cmd.finish && do_lock),
      .waddr    (tid_idx),
      .wdata    (new_label),
      .raddr    (scan_addr),
      .rdata_ff (ram_rdata)
   );

   assign tid_ext   = {{IDX_W{1'b0}}, tid_ff};
   assign idx_ext   = {{bta_pkg::TID_W{1'b0}}, pend_idx_ff};
   assign win_ext   = {{bta_pkg::TID_W{1'b0}}, win_ff};
   assign tid_idx   = tid_ext[IDX_W-1:0];
   assign in_range  = tid_ext < EXT_W'(THREADS);
   assign is_upd    = (op_ff == bta_pkg::REQ_LOCK) || (op_ff == bta_pkg::REQ_UNLOCK);
   assign excl      = is_upd && (idx_ext == tid_ext);
   assign do_lock   = (op_ff == bta_pkg::REQ_LOCK) && in_range;
   assign rd_label  = entry_vld_ff[pend_idx_ff] ? ram_rdata : '0;
   assign take      = flag_ff[pend_idx_ff] && !excl && (!found_ff || rd_label < best_ff);

   assign top_label = '1;
   assign saturated = (max_ff == top_label);
   assign new_label = saturated ? top_label : max_ff + 1'b1;
   assign tid_wins  = !found_ff || (new_label < best_ff)
                      || ((new_label == best_ff) && (tid_ext < win_ext));

   // scan accumulators
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff    <= req_type;
         tid_ff   <= thread_id;
         max_ff   <= '0;
         best_ff  <= '0;
         cur_ff   <= '0;
         found_ff <= 1'b0;
         win_ff   <= '0;
      end else if (pend_vld_ff) begin
         if (rd_label > max_ff) begin
            max_ff <= rd_label;
         end
         if (idx_ext == tid_ext) begin
            cur_ff <= rd_label;
         end
         if (take) begin
            found_ff <= 1'b1;
            best_ff  <= rd_label;
            win_ff   <= pend_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
      end else begin
         pend_vld_ff <= cmd.scan_rd;
      end
      pend_idx_ff <= scan_addr;
   end

   // flag and entry-valid update
   always_comb begin
      flag_in      = flag_ff;
      entry_vld_in = entry_vld_ff;
      if (cmd.finish) begin
         if (op_ff == bta_pkg::REQ_CLEAR) begin
            flag_in      = '0;
            entry_vld_in = '0;
         end else if (do_lock) begin
            flag_in[tid_idx]      = 1'b1;
            entry_vld_in[tid_idx] = 1'b1;
         end else if ((op_ff == bta_pkg::REQ_UNLOCK) && in_range) begin
            flag_in[tid_idx] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff      <= '0;
         entry_vld_ff <= '0;
      end else begin
         flag_ff      <= flag_in;
         entry_vld_ff <= entry_vld_in;
      end
   end

   // result
   always_comb begin
      gt_src = win_ff;
      al_src = '0;
      gv_in  = found_ff;
      rg_in  = found_ff && in_range && (op_ff != bta_pkg::REQ_CLEAR) && (win_ext == tid_ext);
      if (do_lock) begin
         gv_in  = 1'b1;
         rg_in  = tid_wins;
         al_src = new_label;
         if (tid_wins) begin
            gt_src = tid_idx;
         end
      end else if (in_range && (op_ff != bta_pkg::REQ_CLEAR)) begin
         al_src = cur_ff;
      end
      if (op_ff == bta_pkg::REQ_CLEAR) begin
         gv_in  = 1'b0;
         rg_in  = 1'b0;
         gt_src = '0;
      end
      gt_in = bta_pkg::TID_W'({{bta_pkg::TID_W{1'b0}}, gt_src});
      al_in = bta_pkg::ASSIGNED_W'({{bta_pkg::ASSIGNED_W{1'b0}}, al_src});
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         gv_ff  <= gv_in;
         gt_ff  <= gt_in;
         al_ff  <= al_in;
         rg_ff  <= rg_in;
         ovf_ff <= do_lock && saturated;
      end
   end

   assign grant_valid       = gv_ff;
   assign grant_thread      = gt_ff;
   assign assigned_label    = al_ff;
   assign requester_granted = rg_ff;
   assign label_overflow    = ovf_ff;

endmodule

// ===== src/bakery_ticket_arbiter.sv =====
// bakery_ticket_arbiter: ticket-label mutual-exclusion arbiter for THREADS threads
// a lock or unlock request passes the label scan, a drain state and a final state before its
// result is registered, a clear goes straight to the final state; requests are taken one at a
// time, paced by the one-entry-per-cycle read of the label ram during the max and winner scan
// a new request is taken while the previous result still waits on rsp_chan
// synchronous reset clears all waiting flags and labels and empties the result register
module bakery_ticket_arbiter #(
   parameter int THREADS    = 8,
   parameter int LABEL_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   bta_req_if.sink    req_chan,
   bta_rsp_if.source  rsp_chan
);

   bta_pkg::cmd_type           cmd;
   logic [$clog2(THREADS)-1:0] scan_addr;

   bta_ctrl #(
      .THREADS (THREADS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_type  (req_chan.req_type),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .scan_addr (scan_addr)
   );

   bta_dpath #(
      .THREADS    (THREADS),
      .LABEL_BITS (LABEL_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .scan_addr         (scan_addr),
      .req_type          (req_chan.req_type),
      .thread_id         (req_chan.thread_id),
      .grant_valid       (rsp_chan.grant_valid),
      .grant_thread      (rsp_chan.grant_thread),
      .assigned_label    (rsp_chan.assigned_label),
      .requester_granted (rsp_chan.requester_granted),
      .label_overflow    (rsp_chan.label_overflow)
   );

endmodule

// ===== tb/bakery_ticket_arbiter_test.sv =====
// bakery_ticket_arbiter_test: self-checking bench for the bakery ticket arbiter,
// with a scoreboard class that predicts flags, labels and the winner per request
// depends on bta_pkg, bta_req_if, bta_rsp_if and bakery_ticket_arbiter
`timescale 1ns / 100ps

module bakery_ticket_arbiter_test;

   localparam int NUM_THREADS = 8;
   localparam int RT_W        = bta_pkg::REQ_TYPE_W;
   localparam int TID_W       = bta_pkg::TID_W;
   localparam int LABEL_W     = bta_pkg::ASSIGNED_W;
   localparam logic [RT_W-1:0] REQ_SPARE = 2'd3;
   localparam int RANDOM_PER_PHASE = 633;
   localparam int LONG_HOLD = 300;

   typedef struct packed {
      logic               grant_valid;
      logic [TID_W-1:0]   grant_thread;
      logic [LABEL_W-1:0] assigned_label;
      logic               requester_granted;
      logic               label_overflow;
   } grant_type;

   class ticket_scoreboard;
      bit                 waiting[NUM_THREADS];
      logic [LABEL_W-1:0] label[NUM_THREADS];
      grant_type          grant_q[$];
      int                 errors;
      int                 checked;
      int                 n_lock, n_unlock, n_clear, n_spare;
      logic [LABEL_W-1:0] top_label_seen;

      function new();
         clear_tickets();
         errors = 0;
         checked = 0;
         n_lock = 0;
         n_unlock = 0;
         n_clear = 0;
         n_spare = 0;
         top_label_seen = '0;
      endfunction

      function void clear_tickets();
         for (int k = 0; k < NUM_THREADS; k++) begin
            waiting[k] = 1'b0;
            label[k] = '0;
         end
      endfunction

      // flagged thread with smallest label, lower id on ties; -1 when none
      function int winner_of();
         int win;
         win = -1;
         for (int k = 0; k < NUM_THREADS; k++)
            if (waiting[k] && (win < 0 || label[k] < label[win]))
               win = k;
         return win;
      endfunction

      function void note_request(logic [RT_W-1:0] rt, logic [TID_W-1:0] tid);
         grant_type          want;
         logic [LABEL_W-1:0] mx;
         bit                 in_range;
         int                 win;
         in_range = (int'(tid) < NUM_THREADS);
         want = '0;
         case (rt)
            bta_pkg::REQ_CLEAR: begin
               clear_tickets();
               n_clear++;
            end
            bta_pkg::REQ_LOCK: begin
               n_lock++;
               if (in_range) begin
                  mx = '0;
                  for (int k = 0; k < NUM_THREADS; k++)
                     if (label[k] > mx)
                        mx = label[k];
                  waiting[tid] = 1'b1;
                  if (mx == '1) begin
                     label[tid] = '1;
                     want.label_overflow = 1'b1;
                  end else begin
                     label[tid] = mx + 1'b1;
                  end
                  if (label[tid] > top_label_seen)
                     top_label_seen = label[tid];
               end
            end
            bta_pkg::REQ_UNLOCK: begin
               n_unlock++;
               if (in_range)
                  waiting[tid] = 1'b0;
            end
            default: n_spare++;
         endcase
         if (rt != bta_pkg::REQ_CLEAR && in_range)
            want.assigned_label = label[tid];
         win = winner_of();
         if (win >= 0) begin
            want.grant_valid = 1'b1;
            want.grant_thread = TID_W'(win);
            want.requester_granted = in_range && rt != bta_pkg::REQ_CLEAR
                                     && win == int'(tid);
         end
         grant_q.push_back(want);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 50)
            $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_result(grant_type got);
         grant_type want;
         if (grant_q.size() == 0) begin
            report($sformatf("result with no request outstanding: %p", got));
            return;
         end
         want = grant_q.pop_front();
         checked++;
         if (got.grant_valid !== want.grant_valid)
            report($sformatf("result %0d grant_valid %b, want %b",
                             checked, got.grant_valid, want.grant_valid));
         if (got.grant_thread !== want.grant_thread)
            report($sformatf("result %0d grant_thread %0d, want %0d",
                             checked, got.grant_thread, want.grant_thread));
         if (got.assigned_label !== want.assigned_label)
            report($sformatf("result %0d assigned_label %0h, want %0h",
                             checked, got.assigned_label, want.assigned_label));
         if (got.requester_granted !== want.requester_granted)
            report($sformatf("result %0d requester_granted %b, want %b",
                             checked, got.requester_granted, want.requester_granted));
         if (got.label_overflow !== want.label_overflow)
            report($sformatf("result %0d label_overflow %b, want %b",
                             checked, got.label_overflow, want.label_overflow));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bta_req_if req_bus ();
   bta_rsp_if rsp_bus ();

   bakery_ticket_arbiter #(
      .THREADS   (NUM_THREADS),
      .LABEL_BITS(LABEL_W)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   ticket_scoreboard sb = new();

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit hold_rsp = 1'b0;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.req_type = bta_pkg::REQ_LOCK;
      req_bus.thread_id = '0;
      rsp_bus.ready = 1'b0;
   end

   // receiver: random back-pressure, or one long hold-off when asked
   initial begin
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         sb.check_result({rsp_bus.grant_valid, rsp_bus.grant_thread,
                          rsp_bus.assigned_label, rsp_bus.requester_granted,
                          rsp_bus.label_overflow});
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input logic [RT_W-1:0] rt, input logic [TID_W-1:0] tid);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= rt;
      req_bus.thread_id <= tid;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
      sb.note_request(rt, tid);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.grant_q.size() != 0)
         @(negedge clock);
      repeat (NUM_THREADS + 4) @(negedge clock);
   endtask

   // mostly well-formed lock/unlock traffic, winners releasing often
   task automatic random_request();
      logic [RT_W-1:0]  rt;
      logic [TID_W-1:0] tid;
      int               pick;
      int               win;
      pick = $urandom_range(99);
      tid = TID_W'($urandom_range(NUM_THREADS - 1));
      win = sb.winner_of();
      if (pick < 4) begin
         rt = bta_pkg::REQ_CLEAR;
      end else if (pick < 10) begin
         rt = RT_W'($urandom_range(3));
      end else if (pick < 35 && win >= 0) begin
         rt = bta_pkg::REQ_UNLOCK;
         tid = TID_W'(win);
      end else begin
         rt = sb.waiting[tid] ? bta_pkg::REQ_UNLOCK : bta_pkg::REQ_LOCK;
      end
      send_request(rt, tid);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: fill all threads, stale labels, spare code, clear, relock
      send_request(bta_pkg::REQ_CLEAR, 3'd0);
      for (int k = 0; k < NUM_THREADS; k++)
         send_request(bta_pkg::REQ_LOCK, TID_W'(k));
      send_request(bta_pkg::REQ_UNLOCK, 3'd0);
      send_request(bta_pkg::REQ_UNLOCK, 3'd0);
      send_request(REQ_SPARE, 3'd5);
      send_request(bta_pkg::REQ_LOCK, 3'd0);
      send_request(bta_pkg::REQ_UNLOCK, 3'd3);
      send_request(bta_pkg::REQ_CLEAR, 3'd7);
      send_request(bta_pkg::REQ_UNLOCK, 3'd4);
      send_request(REQ_SPARE, 3'd2);
      send_request(bta_pkg::REQ_LOCK, 3'd7);
      send_request(bta_pkg::REQ_LOCK, 3'd7);
      send_request(bta_pkg::REQ_UNLOCK, 3'd7);
      send_request(bta_pkg::REQ_LOCK, 3'd2);
      wait_drained();

      send_idle_pct = 10;
      rsp_idle_pct = 71;
      repeat (RANDOM_PER_PHASE) random_request();
      wait_drained();

      send_idle_pct = 71;
      rsp_idle_pct = 10;
      repeat (RANDOM_PER_PHASE) random_request();
      wait_drained();

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_rsp = 1'b1;
      repeat (40) random_request();
      wait_drained();
      repeat (RANDOM_PER_PHASE) random_request();
      wait_drained();

      if (sb.grant_q.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.grant_q.size()));
      $display("covered %0d locks, %0d unlocks, %0d clears, %0d spare-code requests",
               sb.n_lock, sb.n_unlock, sb.n_clear, sb.n_spare);
      $display("checked %0d results, highest label %0d, %0d mismatches",
               sb.checked, sb.top_label_seen, sb.errors);
      if (sb.errors == 0)
         $display("bakery_ticket_arbiter regression: pass");
      else
         $display("bakery_ticket_arbiter regression: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", sb.grant_q.size());
      $display("bakery_ticket_arbiter regression: fail");
      $finish;
   end

endmodule
